// ----- rtl/arf_pkg.sv -----
// Package for the alignment redundancy filter.
// Holds the item, configuration and control types and the residue classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arf_pkg;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 256;
  localparam int CFG_WIDTH       = 17;
  localparam int CFG_IDX_WIDTH   = 2;
  localparam logic [16:0] Q16_ONE = 17'd65536;

  typedef struct packed {
    logic [7:0] residue;
    logic       reference_row;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  stored_slot;
    logic [10:0] residue_count;
  } out_item_t;

  typedef struct packed {
    logic [10:0] row_length;
    logic [16:0] coverage_cut;
    logic [16:0] identity_cut;
    logic        identity_filter_on;
  } cfg_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    R_ROW_LENGTH   = 2'd0,
    R_COVERAGE_CUT = 2'd1,
    R_IDENTITY_CUT = 2'd2,
    R_FILTER_ON    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    V_LOW_COVERAGE   = 3'd0,
    V_REDUNDANT      = 3'd1,
    V_KEPT           = 3'd2,
    V_KEPT_NOT_STORED = 3'd3,
    V_REF_STORED     = 3'd4,
    V_REF_DROPPED    = 3'd5
  } verdict_t;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_CALC,
    S_DECIDE,
    S_SCAN,
    S_SCAN_END,
    S_POST,
    S_COPY,
    S_COPY_END,
    S_DONE
  } state_t;

  function automatic logic is_amino(input logic [7:0] b);
    logic r;
    case (b) inside
      "A", "C", "D", "E", "F", "G", "H", "I", "K", "L",
      "M", "N", "P", "Q", "R", "S", "T", "V", "W", "Y": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/arf_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data.
// Used for the row buffer and the row store. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module arf_ram #(
  parameter int AW    = 10,
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/arf_ctrl.sv -----
// Sequencer and shared compare unit of the alignment redundancy filter.
// Uses arf_pkg and two arf_ram instances (row buffer and row store).
`timescale 1ns / 1ps
`default_nettype none

module arf_ctrl
  import arf_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire cfg_t      cfg,
  output logic           res_valid,
  input  wire logic      res_ready,
  output out_item_t      res
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int CW1 = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW1 = $clog2(MAX_ROWS + 1);
  localparam int PW  = 17 + CW1;

  state_t state_r, state_nxt;

  logic [CW-1:0]  col_r, col_nxt;
  logic [CW1-1:0] cnt_r, cnt_nxt;
  logic [CW1-1:0] n_r, n_nxt;
  logic           ref_r, ref_nxt;
  logic [PW-1:0]  pcov_r, pcov_nxt;
  logic [PW-1:0]  pid_r, pid_nxt;
  logic [CW-1:0]  scol_r, scol_nxt;
  logic [RW-1:0]  slot_r, slot_nxt;
  logic           sp_r, sp_nxt;
  logic           lastp_r, lastp_nxt;
  logic           cp_r, cp_nxt;
  logic [CW-1:0]  cpcol_r, cpcol_nxt;
  logic [CW1-1:0] d_r, d_nxt;
  logic           red_r, red_nxt;
  logic [RW1-1:0] rows_r, rows_nxt;
  verdict_t       verdict_r, verdict_nxt;
  logic [RW-1:0]  oslot_r, oslot_nxt;

  logic [CW1-1:0] eff;
  logic           accept, row_last, in_amino, full, cov_low, try_scan;
  logic           scol_last, slot_last, mis;
  logic [CW1-1:0] sum, maxd;
  logic [7:0]     cur_rdata, st_rdata;

  // Out-of-range lengths are pinned to 1 and MAX_COLUMNS.
  always_comb begin
    if (cfg.row_length == '0) begin
      eff = CW1'(1);
    end else if (32'(cfg.row_length) > 32'(MAX_COLUMNS)) begin
      eff = CW1'(MAX_COLUMNS);
    end else begin
      eff = CW1'(cfg.row_length);
    end
  end

  assign in_ready  = (state_r == S_COLLECT);
  assign accept    = in_valid && in_ready;
  assign in_amino  = is_amino(in_data.residue);
  assign row_last  = (CW1'(col_r) + CW1'(1)) >= eff;
  assign full      = (rows_r == RW1'(MAX_ROWS));
  assign cov_low   = PW'({cnt_r, 16'd0}) < pcov_r;
  assign try_scan  = cfg.identity_filter_on && (cfg.identity_cut <= Q16_ONE) && (rows_r != '0);
  assign scol_last = (scol_r == CW'(n_r - CW1'(1)));
  assign slot_last = (RW1'(slot_r) == rows_r - RW1'(1));
  assign maxd      = CW1'(pid_r >> 16);

  arf_ram #(.AW(CW), .WIDTH(8)) u_cur_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (col_r),
    .wdata (in_data.residue),
    .raddr (scol_r),
    .rdata (cur_rdata)
  );

  arf_ram #(.AW(RW + CW), .WIDTH(8)) u_store_ram (
    .clk   (clk),
    .we    (cp_r),
    .waddr ({RW'(rows_r), cpcol_r}),
    .wdata (cur_rdata),
    .raddr ({slot_r, scol_r}),
    .rdata (st_rdata)
  );

  // Shared compare unit: one column of one stored row per cycle.
  assign mis = is_amino(cur_rdata) && (cur_rdata != st_rdata);
  assign sum = d_r + CW1'(mis);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_COLLECT: if (accept && row_last) state_nxt = S_CALC;
      S_CALC:    state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (ref_r) begin
          state_nxt = full ? S_DONE : S_COPY;
        end else if (cov_low) begin
          state_nxt = S_DONE;
        end else if (try_scan) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = full ? S_DONE : S_COPY;
        end
      end
      S_SCAN:     if (scol_last && slot_last) state_nxt = S_SCAN_END;
      S_SCAN_END: state_nxt = S_POST;
      S_POST: begin
        if (red_r || full) state_nxt = S_DONE;
        else state_nxt = S_COPY;
      end
      S_COPY:     if (scol_last) state_nxt = S_COPY_END;
      S_COPY_END: state_nxt = S_DONE;
      S_DONE:     if (res_ready) state_nxt = S_COLLECT;
      default:    state_nxt = S_COLLECT;
    endcase
  end

  always_comb begin
    col_nxt     = col_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    ref_nxt     = ref_r;
    pcov_nxt    = pcov_r;
    pid_nxt     = pid_r;
    scol_nxt    = scol_r;
    slot_nxt    = slot_r;
    sp_nxt      = 1'b0;
    lastp_nxt   = 1'b0;
    cp_nxt      = 1'b0;
    cpcol_nxt   = cpcol_r;
    d_nxt       = d_r;
    red_nxt     = red_r;
    rows_nxt    = rows_r;
    verdict_nxt = verdict_r;
    oslot_nxt   = oslot_r;

    if (sp_r) begin
      if (lastp_r) begin
        d_nxt = '0;
        if (sum <= maxd) red_nxt = 1'b1;
      end else begin
        d_nxt = sum;
      end
    end

    unique case (state_r)
      S_COLLECT: begin
        if (accept) begin
          cnt_nxt = cnt_r + CW1'(in_amino);
          ref_nxt = in_data.reference_row;
          if (row_last) begin
            n_nxt   = CW1'(col_r) + CW1'(1);
            col_nxt = '0;
          end else begin
            col_nxt = col_r + CW'(1);
          end
        end
      end
      S_CALC: begin
        pcov_nxt = PW'(cfg.coverage_cut) * PW'(eff);
        pid_nxt  = PW'(Q16_ONE - cfg.identity_cut) * PW'(cnt_r);
      end
      S_DECIDE: begin
        scol_nxt  = '0;
        slot_nxt  = '0;
        d_nxt     = '0;
        red_nxt   = 1'b0;
        oslot_nxt = '0;
        if (ref_r) begin
          verdict_nxt = full ? V_REF_DROPPED : V_REF_STORED;
        end else if (cov_low) begin
          verdict_nxt = V_LOW_COVERAGE;
        end else begin
          verdict_nxt = full ? V_KEPT_NOT_STORED : V_KEPT;
        end
      end
      S_SCAN: begin
        sp_nxt    = 1'b1;
        lastp_nxt = scol_last;
        if (scol_last) begin
          scol_nxt = '0;
          slot_nxt = slot_r + RW'(1);
        end else begin
          scol_nxt = scol_r + CW'(1);
        end
      end
      S_POST: begin
        scol_nxt = '0;
        if (red_r) verdict_nxt = V_REDUNDANT;
        else if (full) verdict_nxt = V_KEPT_NOT_STORED;
        else verdict_nxt = V_KEPT;
      end
      S_COPY: begin
        cp_nxt    = 1'b1;
        cpcol_nxt = scol_r;
        scol_nxt  = scol_r + CW'(1);
      end
      S_COPY_END: begin
        // The last byte is written on this edge at the old slot count, which moves on the same edge.
        rows_nxt  = rows_r + RW1'(1);
        oslot_nxt = RW'(rows_r);
      end
      S_DONE: begin
        if (res_ready) cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
      col_r   <= '0;
      cnt_r   <= '0;
      rows_r  <= '0;
      sp_r    <= 1'b0;
      cp_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
      rows_r  <= rows_nxt;
      sp_r    <= sp_nxt;
      cp_r    <= cp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    ref_r     <= ref_nxt;
    pcov_r    <= pcov_nxt;
    pid_r     <= pid_nxt;
    scol_r    <= scol_nxt;
    slot_r    <= slot_nxt;
    lastp_r   <= lastp_nxt;
    cpcol_r   <= cpcol_nxt;
    d_r       <= d_nxt;
    red_r     <= red_nxt;
    verdict_r <= verdict_nxt;
    oslot_r   <= oslot_nxt;
  end

  assign res_valid         = (state_r == S_DONE);
  assign res.verdict       = verdict_r;
  assign res.stored_slot   = 8'(oslot_r);
  assign res.residue_count = 11'(cnt_r);

endmodule

`default_nettype wire

// ----- rtl/alignment_redundancy_filter.sv -----
// Alignment redundancy filter: bytes of aligned rows come in one item per
// cycle while a row is collected. At the end of each row a non-reference
// row is screened for coverage and, if the identity scan runs, compared
// with every stored row. A kept or reference row is stored if there is room.
// Input channel (in_valid/in_ready/in_data): one residue byte per item, and
// in_ready stays high while a row is being collected. The last byte of a row
// closes it, and in_ready stays low until that row's result is handed to
// the output register.
// Result channel (out_valid/out_ready/out_data): one item per finished row.
// End-of-row work computes the thresholds and decides the verdict, then runs
// the identity scan over the stored rows when it applies, and copies a row
// that is to be stored into the row store. The scan reads one byte of one
// stored row per cycle from a single port of the row store.
// The output register lets the next row start while a result is still held
// by a stalled receiver; a second result waits in the sequencer.
// Configuration: cfg_we writes cfg_data into register cfg_index.
// Reset (rst_n low, synchronous) empties the store, restarts the row and
// loads the register defaults. Stored bytes need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module alignment_redundancy_filter
  import arf_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output out_item_t                     out_data,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]     cfg_data
);

  cfg_t      cfg_r;
  logic      res_valid, res_ready, out_valid_r;
  out_item_t res, out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_length         <= 11'd1024;
      cfg_r.coverage_cut       <= 17'd0;
      cfg_r.identity_cut       <= 17'd58982;
      cfg_r.identity_filter_on <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        R_ROW_LENGTH:   cfg_r.row_length         <= cfg_data[10:0];
        R_COVERAGE_CUT: cfg_r.coverage_cut       <= cfg_data;
        R_IDENTITY_CUT: cfg_r.identity_cut       <= cfg_data;
        R_FILTER_ON:    cfg_r.identity_filter_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  arf_ctrl #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/arf_checker.sv -----
// Port-level checks for the alignment redundancy filter.
// Uses arf_pkg; bound to alignment_redundancy_filter at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module arf_checker
  import arf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.verdict <= V_REF_DROPPED)
    else $error("verdict code out of range");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.verdict != V_KEPT && out_data.verdict != V_REF_STORED
    |-> out_data.stored_slot == 8'd0)
    else $error("slot reported for a row that was not stored");

endmodule

bind alignment_redundancy_filter arf_checker u_arf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ----- sim/alignment_redundancy_filter_tb.sv -----
// Testbench for alignment_redundancy_filter: drives rows of residue bytes,
// predicts each row's verdict, slot and residue count, and checks every result.
// Depends on arf_pkg and the alignment_redundancy_filter RTL.
`timescale 1ns / 1ps

module alignment_redundancy_filter_tb;
  import arf_pkg::*;

  localparam int COLS = 1024;
  localparam int SLOTS = 256;
  localparam string AMINO = "ACDEFGHIKLMNPQRSTVWY";

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  alignment_redundancy_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: its own copy of the row store and the registers.
  bit [7:0] row_mem [SLOTS][COLS];
  int stored_len [SLOTS];
  bit [7:0] cur_row [COLS];
  int col_pos, amino_cnt, rows_kept;
  int m_len, m_cov, m_idc, m_filt;

  out_item_t expected_rows [$];
  int errors = 0;
  int verdict_seen [6];
  int items_sent = 0;
  bit gap_free;

  function automatic bit is_residue(input bit [7:0] b);
    for (int k = 0; k < 20; k++)
      if (AMINO[k] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return AMINO[$urandom_range(0, 19)];
    if (r < 8) return "-";
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic predict_byte(input bit [7:0] b, input bit rf);
    int eff, n, cnt, slot, maxd, d;
    bit hit, full;
    out_item_t r;
    eff = (m_len == 0) ? 1 : ((m_len > COLS) ? COLS : m_len);
    if (col_pos >= COLS) col_pos = COLS - 1;
    cur_row[col_pos] = b;
    if (is_residue(b)) amino_cnt++;
    if (col_pos + 1 < eff) begin
      col_pos++;
      return;
    end
    n = col_pos + 1;
    cnt = amino_cnt;
    col_pos = 0;
    amino_cnt = 0;
    full = rows_kept >= SLOTS;
    slot = 0;
    hit = 1'b0;
    if (rf) begin
      r.verdict = full ? V_REF_DROPPED : V_REF_STORED;
    end else if (longint'(cnt) * 65536 < longint'(m_cov) * eff) begin
      r.verdict = V_LOW_COVERAGE;
    end else begin
      if (m_filt != 0 && m_idc <= 65536) begin
        maxd = int'((longint'(65536 - m_idc) * cnt) >> 16);
        for (int s = 0; s < rows_kept && !hit; s++) begin
          d = 0;
          for (int i = 0; i < n; i++)
            if (is_residue(cur_row[i]) && row_mem[s][i] != cur_row[i]) d++;
          if (d <= maxd) hit = 1'b1;
        end
      end
      if (hit) r.verdict = V_REDUNDANT;
      else r.verdict = full ? V_KEPT_NOT_STORED : V_KEPT;
    end
    if (r.verdict == V_KEPT || r.verdict == V_REF_STORED) begin
      for (int i = 0; i < n; i++) row_mem[rows_kept][i] = cur_row[i];
      stored_len[rows_kept] = n;
      slot = rows_kept;
      rows_kept++;
    end
    r.stored_slot = slot[7:0];
    r.residue_count = cnt[10:0];
    expected_rows.insert(expected_rows.size(), r);
  endtask

  // Sends one item and updates the predictor at the edge that accepts it.
  task automatic send_item(input bit [7:0] b, input bit rf);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.residue <= b;
    in_data.reference_row <= rf;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, rf);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_row(input int n);
    bit [7:0] row [COLS];
    int mode, src;
    mode = $urandom_range(0, 3);
    src = -1;
    if ((mode == 1 || mode == 2) && rows_kept > 0) begin
      src = $urandom_range(0, rows_kept - 1);
      for (int t = 0; t < rows_kept && stored_len[src] < n; t++)
        src = (src + 1) % rows_kept;
      if (stored_len[src] < n) src = -1;
    end
    for (int i = 0; i < n; i++) begin
      if (src >= 0)
        row[i] = ($urandom_range(0, 7) == 0) ? pick_byte() : row_mem[src][i];
      else if (mode == 0)
        row[i] = 8'($urandom_range(0, 255));
      else
        row[i] = pick_byte();
    end
    gap_free = ($urandom_range(0, 3) == 0);
    // The reference flag only matters on the last byte of a row.
    for (int i = 0; i < n - 1; i++) send_item(row[i], 1'($urandom_range(0, 1)));
    send_item(row[n-1], $urandom_range(0, 7) == 0);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_WIDTH-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      R_ROW_LENGTH:   m_len = val & 'h7FF;
      R_COVERAGE_CUT: m_cov = val & 'h1FFFF;
      R_IDENTITY_CUT: m_idc = val & 'h1FFFF;
      R_FILTER_ON:    m_filt = val & 1;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic run_phase(input int len, input int cov, input int idc,
                           input int filt, input int rows);
    int n;
    wait_idle();
    cfg_write(R_ROW_LENGTH, len);
    cfg_write(R_COVERAGE_CUT, cov);
    cfg_write(R_IDENTITY_CUT, idc);
    cfg_write(R_FILTER_ON, filt);
    n = (len == 0) ? 1 : ((len > COLS) ? COLS : len);
    repeat (rows) send_row(n);
  endtask

  task automatic test_directed();
    string letters = "ACDEFGHI";
    bit [7:0] odd [8] = '{8'h00, 8'hFF, "-", ".", "Y", "W", "V", "T"};
    cfg_write(R_ROW_LENGTH, 8);
    gap_free = 1'b0;
    // A fresh row is kept, its twin is redundant, then a reference row.
    for (int i = 0; i < 8; i++) send_item(letters[i], 1'b0);
    for (int i = 0; i < 8; i++) send_item(letters[i], 1'b0);
    for (int i = 0; i < 8; i++) send_item(odd[i], i == 7);
  endtask

  task automatic test_coverage_and_identity();
    // Row lengths only shrink while the filter compares, so no scan reads
    // stored bytes that were never written.
    run_phase(8, 32768, 58982, 1, 20);
    run_phase(8, 0, 0, 1, 10);
    run_phase(4, 65536, 131071, 1, 40);
    run_phase(4, 16384, 32768, 1, 40);
    run_phase(2, 0, 65536, 1, 50);
  endtask

  task automatic test_store_fill();
    run_phase(1, 0, 58982, 0, 0);
    while (rows_kept < SLOTS) send_row(1);
    repeat (10) send_row(1);
    run_phase(1, 0, 58982, 1, 60);
  endtask

  task automatic test_length_limits();
    run_phase(0, 0, 58982, 0, 30);
    run_phase(2047, 0, 58982, 0, 1);
    run_phase(1, 131071, 0, 0, 20);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $error("result with no row pending: verdict %0d", out_data.verdict);
        errors++;
      end else begin
        out_item_t e;
        e = expected_rows.pop_front();
        if (out_data.verdict != e.verdict) begin
          $error("verdict expected %0d got %0d", e.verdict, out_data.verdict);
          errors++;
        end
        if (out_data.stored_slot != e.stored_slot) begin
          $error("stored_slot expected %0d got %0d", e.stored_slot, out_data.stored_slot);
          errors++;
        end
        if (out_data.residue_count != e.residue_count) begin
          $error("residue_count expected %0d got %0d",
                 e.residue_count, out_data.residue_count);
          errors++;
        end
        if (e.verdict < 6) verdict_seen[e.verdict]++;
      end
    end
  end

  // Receiver: stalls a random number of cycles before taking each result.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    col_pos = 0;
    amino_cnt = 0;
    rows_kept = 0;
    m_len = 1024;
    m_cov = 0;
    m_idc = 58982;
    m_filt = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_coverage_and_identity();
    test_store_fill();
    test_length_limits();
    wait_idle();
    $display("Sent %0d items; rows seen: low coverage %0d, redundant %0d, kept %0d,",
             items_sent, verdict_seen[0], verdict_seen[1], verdict_seen[2]);
    $display("kept not stored %0d, reference stored %0d, reference dropped %0d.",
             verdict_seen[3], verdict_seen[4], verdict_seen[5]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
